// ===== design/assert_macros.svh =====
// Assertion macros shared by the design modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/lkc_pkg.sv =====
// Types and constants of the keyed least-recently-used cache.
package lkc_pkg;

	localparam int NUM_ENTRIES = 16;
	localparam int IDX_W       = 4;
	localparam int CNT_W       = 5;
	localparam int KEY_W       = 32;
	localparam int HANDLE_W    = 32;
	localparam int CMD_W       = 3;
	localparam int STATUS_W    = 2;

	localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PROBE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NULL = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] value_out;
		logic                evicted;
		logic [KEY_W-1:0]    evicted_key;
		logic [CNT_W-1:0]    occupancy;
	} rsp_t;

	// Operation after classification by the front end.
	typedef enum logic [2:0] {
		OP_ADD,
		OP_GET,
		OP_PROBE,
		OP_REMOVE,
		OP_CLEAR,
		OP_NULL,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] value;
	} job_t;

endpackage

// ===== design/lkc_front.sv =====
// Front end: accepts items, classifies the command and queues jobs for the engine.
module lkc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  lkc_pkg::req_t    req,
	output logic             job_valid,
	input  logic             job_ready,
	output lkc_pkg::job_t    job
);

	`include "assert_macros.svh"

	lkc_pkg::job_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	lkc_pkg::job_t cls;
	logic          push;
	logic          pop;

	always_comb begin
		cls.key   = req.key;
		cls.value = req.value;
		unique case (req.command)
			lkc_pkg::CMD_ADD: begin
				cls.op = (req.value == '0) ? lkc_pkg::OP_NULL : lkc_pkg::OP_ADD;
			end
			lkc_pkg::CMD_GET:    cls.op = lkc_pkg::OP_GET;
			lkc_pkg::CMD_PROBE:  cls.op = lkc_pkg::OP_PROBE;
			lkc_pkg::CMD_REMOVE: cls.op = lkc_pkg::OP_REMOVE;
			lkc_pkg::CMD_CLEAR:  cls.op = lkc_pkg::OP_CLEAR;
			default:             cls.op = lkc_pkg::OP_NOP;
		endcase
	end

	assign req_ready = (cnt_q != 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign job       = slot_q[rd_ptr_q];
	assign push      = req_valid && req_ready;
	assign pop       = job_valid && job_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`ASSERT_ALWAYS(a_queue_bound, clk, arst_n, cnt_q <= 2'd2)

endmodule

// ===== design/lkc_engine.sv =====
// Back end: sequencer that trims, looks up and updates the cache entries.
module lkc_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [lkc_pkg::CNT_W-1:0] cfg_data,
	input  logic                      job_valid,
	output logic                      job_ready,
	input  lkc_pkg::job_t             job,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output lkc_pkg::rsp_t             rsp
);

	`include "assert_macros.svh"

	localparam int N = lkc_pkg::NUM_ENTRIES;

	typedef enum logic [1:0] {S_IDLE, S_TRIM, S_EXEC, S_INS} state_t;
	typedef enum logic [2:0] {ACT_NONE, ACT_DROP, ACT_REF, ACT_INS, ACT_CLR} act_t;

	state_t                            state_q, state_d;
	logic [lkc_pkg::CNT_W-1:0]         cap_q;
	logic [lkc_pkg::KEY_W-1:0]         key_q [N];
	logic [lkc_pkg::HANDLE_W-1:0]      val_q [N];
	logic [N-1:0]                      valid_q, valid_d;
	logic [lkc_pkg::IDX_W-1:0]         rank_q [N];
	logic [lkc_pkg::IDX_W-1:0]         rank_d [N];
	logic [lkc_pkg::CNT_W-1:0]         count_q, count_d;
	lkc_pkg::job_t                     job_q, job_d;
	logic                              hit_q, hit_d;
	logic [lkc_pkg::IDX_W-1:0]         hidx_q, hidx_d;
	logic                              ev_q, ev_d;
	logic [lkc_pkg::KEY_W-1:0]         evkey_q, evkey_d;
	lkc_pkg::rsp_t                     rsp_q, rsp_d;
	logic                              rsp_valid_q, rsp_valid_d;

	logic [lkc_pkg::CNT_W-1:0]         eff_cap;
	logic [N-1:0]                      match;
	logic                              hit_any;
	logic [lkc_pkg::IDX_W-1:0]         hit_idx;
	logic [lkc_pkg::IDX_W-1:0]         old_idx;
	logic [lkc_pkg::IDX_W-1:0]         free_idx;
	act_t                              act;
	logic [lkc_pkg::IDX_W-1:0]         act_idx;
	logic                              wr_en;

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign eff_cap   = (cap_q > lkc_pkg::CNT_W'(N)) ? lkc_pkg::CNT_W'(N) : cap_q;

	// Parallel key compare and the searches for the oldest and a free entry.
	always_comb begin
		hit_any  = 1'b0;
		hit_idx  = '0;
		old_idx  = '0;
		free_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (key_q[i] == job_q.key);
			if (match[i]) begin
				hit_any = 1'b1;
				hit_idx = lkc_pkg::IDX_W'(i);
			end
			if (valid_q[i] && ({1'b0, rank_q[i]} == count_q - 1'b1)) begin
				old_idx = lkc_pkg::IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx = lkc_pkg::IDX_W'(i);
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		job_d       = job_q;
		hit_d       = hit_q;
		hidx_d      = hidx_q;
		ev_d        = ev_q;
		evkey_d     = evkey_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		job_ready   = 1'b0;
		act         = ACT_NONE;
		act_idx     = hidx_q;
		wr_en       = 1'b0;
		rsp_d.status    = lkc_pkg::ST_OK;
		rsp_d.value_out = '0;
		rsp_d.evicted   = ev_q;
		rsp_d.evicted_key = evkey_q;

		unique case (state_q)
			S_IDLE: begin
				if (job_valid && !rsp_valid_q) begin
					job_ready = 1'b1;
					job_d     = job;
					ev_d      = 1'b0;
					evkey_d   = '0;
					state_d   = S_TRIM;
				end
			end
			S_TRIM: begin
				// Entries beyond a lowered capacity go first, one per cycle.
				if (count_q > eff_cap) begin
					act     = ACT_DROP;
					act_idx = old_idx;
					ev_d    = 1'b1;
					evkey_d = key_q[old_idx];
				end else begin
					hit_d   = hit_any;
					hidx_d  = hit_idx;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d     = S_IDLE;
				rsp_valid_d = 1'b1;
				unique case (job_q.op)
					lkc_pkg::OP_ADD: begin
						if (hit_q) begin
							act   = ACT_REF;
							wr_en = 1'b1;
						end else begin
							rsp_valid_d = 1'b0;
							state_d     = S_INS;
							if (count_q >= eff_cap) begin
								act     = ACT_DROP;
								act_idx = old_idx;
								ev_d    = 1'b1;
								evkey_d = key_q[old_idx];
							end
						end
					end
					lkc_pkg::OP_GET: begin
						if (hit_q) begin
							act             = ACT_REF;
							rsp_d.value_out = val_q[hidx_q];
						end else begin
							rsp_d.status = lkc_pkg::ST_MISS;
						end
					end
					lkc_pkg::OP_PROBE: begin
						rsp_d.status = hit_q ? lkc_pkg::ST_OK : lkc_pkg::ST_MISS;
					end
					lkc_pkg::OP_REMOVE: begin
						if (hit_q) begin
							act = ACT_DROP;
						end else begin
							rsp_d.status = lkc_pkg::ST_MISS;
						end
					end
					lkc_pkg::OP_CLEAR: act = ACT_CLR;
					lkc_pkg::OP_NULL:  rsp_d.status = lkc_pkg::ST_NULL;
					default: ;
				endcase
			end
			S_INS: begin
				act         = ACT_INS;
				act_idx     = free_idx;
				wr_en       = 1'b1;
				rsp_valid_d = 1'b1;
				state_d     = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase

		// Recency update: one action per cycle on the whole rank vector.
		valid_d = valid_q;
		count_d = count_q;
		for (int i = 0; i < N; i++) begin
			rank_d[i] = rank_q[i];
			unique case (act)
				ACT_DROP: begin
					if (valid_q[i] && (rank_q[i] > rank_q[act_idx])) begin
						rank_d[i] = rank_q[i] - 1'b1;
					end
				end
				ACT_REF: begin
					if (valid_q[i] && (rank_q[i] < rank_q[act_idx])) begin
						rank_d[i] = rank_q[i] + 1'b1;
					end
				end
				ACT_INS: begin
					if (valid_q[i]) begin
						rank_d[i] = rank_q[i] + 1'b1;
					end
				end
				ACT_CLR: rank_d[i] = '0;
				default: ;
			endcase
		end
		unique case (act)
			ACT_DROP: begin
				valid_d[act_idx] = 1'b0;
				rank_d[act_idx]  = '0;
				count_d          = count_q - 1'b1;
			end
			ACT_REF: rank_d[act_idx] = '0;
			ACT_INS: begin
				valid_d[act_idx] = 1'b1;
				rank_d[act_idx]  = '0;
				count_d          = count_q + 1'b1;
			end
			ACT_CLR: begin
				valid_d = '0;
				count_d = '0;
			end
			default: ;
		endcase
		rsp_d.occupancy = count_d;
		if (!(rsp_valid_d && !rsp_valid_q)) begin
			rsp_d = rsp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_q[act_idx] <= job_q.key;
			val_q[act_idx] <= job_q.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= lkc_pkg::CNT_W'(N);
			valid_q     <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			hidx_q      <= '0;
			ev_q        <= 1'b0;
			evkey_q     <= '0;
			job_q       <= '0;
			rsp_q       <= '0;
			for (int i = 0; i < N; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			state_q     <= state_d;
			valid_q     <= valid_d;
			count_q     <= count_d;
			rsp_valid_q <= rsp_valid_d;
			hit_q       <= hit_d;
			hidx_q      <= hidx_d;
			ev_q        <= ev_d;
			evkey_q     <= evkey_d;
			job_q       <= job_d;
			rsp_q       <= rsp_d;
			for (int i = 0; i < N; i++) begin
				rank_q[i] <= rank_d[i];
			end
			if (cfg_valid && (cfg_data != '0)) begin
				cap_q <= cfg_data;
			end
		end
	end

	`ASSERT_ALWAYS(a_count_matches_valid, clk, arst_n, lkc_pkg::CNT_W'($countones(valid_q)) == count_q)
	`ASSERT_IMPLIES(a_insert_has_room, clk, arst_n, state_q == S_INS, valid_q != '1)
	`ASSERT_IMPLIES(a_trim_before_exec, clk, arst_n, state_q == S_EXEC, count_q <= eff_cap)

endmodule

// ===== design/lru_keyed_cache.sv =====
// Top level of the keyed least-recently-used cache.
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | command, key, value
//   rsp     | out       | rsp_valid / rsp_ready | status, value_out, evicted, evicted_key, occupancy
//   cfg     | in        | cfg_valid / cfg_ready | capacity
// After its request is accepted, a result passes the states S_TRIM and S_EXEC, and S_INS
// as well for an add of a new key; S_TRIM drops entries evicted after a capacity cut one at
// a time, and the engine's sequencer does one rank update per cycle. The engine takes its
// next item the cycle after a result is accepted, not before. A two-item queue keeps the
// request side moving while a result waits. Reset empties the cache and sets capacity to
// sixteen.
module lru_keyed_cache (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  lkc_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output lkc_pkg::rsp_t             rsp,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [lkc_pkg::CNT_W-1:0] cfg_data
);

	logic          job_valid;
	logic          job_ready;
	lkc_pkg::job_t job;

	lkc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	lkc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
